[design/pmt_pkg.sv]
// Shared types, codes and constants of the prepaid multichannel timer.
package pmt_pkg;

    // Channel and store sizing
    localparam int STORE_DEPTH      = 8;
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int CH_W             = 3;
    localparam int TIME_W           = 14;
    localparam int VALUE_W          = 10;
    localparam int MONEY_W          = 16;
    localparam int FUSE_W           = 8;

    // Time arithmetic
    localparam logic [TIME_W-1:0] TIME_CAP   = 14'd9999;
    localparam logic [TIME_W-1:0] TICK_STEP  = 14'd10;
    localparam logic [3:0]        SAVE_PERIOD = 4'd10;

    // Reciprocal of ten in 16 fractional bits, exact for values up to the cap
    localparam logic [12:0]       RECIP_10   = 13'd6554;

    // Grant datapath: money * minutes * 10 fits in 28 bits
    localparam int               PROD_W    = 28;
    localparam int               DCNT_W    = 5;
    localparam logic [DCNT_W-1:0] DIV_LAST = 5'(PROD_W - 1);

    // Register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_MIN_PER_UNIT   = 2'd0,
        REG_MONEY_PER_UNIT = 2'd1,
        REG_FACTORY_MODE   = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        CMD_ADD_MONEY   = 3'd0,
        CMD_MINUTE_TICK = 3'd1,
        CMD_DISP_TICK   = 3'd2,
        CMD_CLEAR_ONE   = 3'd3,
        CMD_CLEAR_ALL   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ERROR = 2'd0,
        KIND_BLANK = 2'd1,
        KIND_NULL  = 2'd2,
        KIND_TIME  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_ADD,
        ST_SWEEP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] min_per_unit;
        logic [7:0] money_per_unit;
        logic       factory_mode;
    } t_cfg;

    // Classified command handed from the front to the back
    typedef struct packed {
        t_cmd               cmd;
        logic [CH_W-1:0]    channel;
        logic [MONEY_W-1:0] money;
        logic [FUSE_W-1:0]  fuse_ok_mask;
    } t_job;

    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic [TIME_W-1:0]  remaining_time;
        t_kind              display_kind;
        logic [VALUE_W-1:0] display_value;
        logic               relay_on;
        logic               save_request;
        logic               last;
    } t_beat;

endpackage

[design/pmt_ifs.sv]
// Valid/ready channel interfaces for command beats and result beats.
interface pmt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [2:0]  channel;
    logic [15:0] money;
    logic [7:0]  fuse_ok_mask;

    modport source (output valid, cmd, channel, money, fuse_ok_mask, input ready);
    modport sink   (input valid, cmd, channel, money, fuse_ok_mask, output ready);
endinterface

interface pmt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_channel;
    logic [13:0] remaining_time;
    logic [1:0]  display_kind;
    logic [9:0]  display_value;
    logic        relay_on;
    logic        save_request;
    logic        last;

    modport source (output valid, out_channel, remaining_time, display_kind, display_value,
                    relay_on, save_request, last, input ready);
    modport sink   (input valid, out_channel, remaining_time, display_kind, display_value,
                    relay_on, save_request, last, output ready);
endinterface

[design/prepaid_multichannel_timer.sv]
// Top level of the prepaid multichannel timer: register port, front end, queue, executor.
//
// Usage: command beats arrive on i_in (add money, minute tick, display tick,
// clear one channel, clear all). Each beat yields zero to eight result beats
// on o_out, one per channel concerned, in channel order; the final beat of a
// command carries last, and save_request is the same on every beat of it.
// Commands with an unused code, an out-of-range channel, or a display tick in
// factory mode are taken and dropped without results.
// Flow: a command is registered in the queue, then the executor runs it
// alone. Add money multiplies, scales by ten, runs the 28-step restoring
// divider (skipped when the divisor is zero, granting nothing) and adds before
// it emits its beat. Ticks are accepted, update the times channel by channel,
// then emit one beat per channel. Clears go straight to emitting their beats.
// A two-entry queue keeps i_in ready while the executor is busy, until both
// entries fill; the output register lets o_out hold a beat while the next is prepared.
// Receiver stall: beats hold on o_out until taken; the executor waits.
// Reset: all channel times, blink phase and minute count clear at once;
// registers return to one minute per one money unit, factory mode off.
// Registers via APB at byte addresses 0, 4, 8; writes land on the access cycle.
module prepaid_multichannel_timer #(
    parameter int NUM_CHANNELS = pmt_pkg::NUM_CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pmt_in_if.sink                      i_in,
    pmt_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pmt_pkg::ADDR_W-1:0]  paddr,
    input  logic [pmt_pkg::DATA_W-1:0]  pwdata,
    output logic [pmt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import pmt_pkg::*;

    t_cfg  r_cfg, n_cfg;
    t_reg  reg_sel;
    logic  wr_en;
    logic  push;
    logic  q_ready;
    logic  q_valid;
    logic  pop;
    t_job  front_job;
    t_job  q_job;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_sel)
                REG_MIN_PER_UNIT:   n_cfg.min_per_unit   = pwdata[7:0];
                REG_MONEY_PER_UNIT: n_cfg.money_per_unit = pwdata[7:0];
                REG_FACTORY_MODE:   n_cfg.factory_mode   = pwdata[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // Register read mux
    always_comb begin
        case (reg_sel)
            REG_MIN_PER_UNIT:   prdata = {24'd0, r_cfg.min_per_unit};
            REG_MONEY_PER_UNIT: prdata = {24'd0, r_cfg.money_per_unit};
            REG_FACTORY_MODE:   prdata = {31'd0, r_cfg.factory_mode};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_per_unit   <= 8'd1;
            r_cfg.money_per_unit <= 8'd1;
            r_cfg.factory_mode   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pmt_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_in      (i_in),
        .i_cfg     (r_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (front_job)
    );

    pmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    pmt_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[design/pmt_front.sv]
// Command front end: accepts command beats, drops ignored ones, queues the rest.
module pmt_front #(
    parameter int NUM_CHANNELS = pmt_pkg::NUM_CHANNELS_DEF
) (
    pmt_in_if.sink         i_in,
    input  pmt_pkg::t_cfg  i_cfg,
    input  logic           i_q_ready,
    output logic           o_push,
    output pmt_pkg::t_job  o_job
);
    import pmt_pkg::*;

    localparam int NCH = (NUM_CHANNELS > STORE_DEPTH) ? STORE_DEPTH : NUM_CHANNELS;

    logic ch_ok;
    logic keep;

    // Accept whenever the queue has room; dropped beats vanish here
    assign i_in.ready = i_q_ready;

    assign ch_ok = ({1'b0, i_in.channel} < (CH_W + 1)'(NCH));

    // Classify the command
    always_comb begin
        case (t_cmd'(i_in.cmd))
            CMD_ADD_MONEY:   keep = ch_ok;
            CMD_CLEAR_ONE:   keep = ch_ok;
            CMD_MINUTE_TICK: keep = 1'b1;
            CMD_CLEAR_ALL:   keep = 1'b1;
            CMD_DISP_TICK:   keep = !i_cfg.factory_mode;
            default:         keep = 1'b0;
        endcase
    end

    assign o_push             = i_in.valid && i_q_ready && keep;
    assign o_job.cmd          = t_cmd'(i_in.cmd);
    assign o_job.channel      = i_in.channel;
    assign o_job.money        = i_in.money;
    assign o_job.fuse_ok_mask = i_in.fuse_ok_mask;

endmodule

[design/pmt_queue.sv]
// Two-entry job queue between the command front end and the executor.
module pmt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pmt_pkg::t_job  i_job,
    output logic           o_ready,
    output logic           o_valid,
    output pmt_pkg::t_job  o_job,
    input  logic           i_pop
);
    import pmt_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (i_pop && o_valid) begin
            n_rptr = !r_rptr;
        end
        case ({i_push, i_pop && o_valid})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

[design/pmt_back.sv]
// Executor: holds channel times, runs grants and ticks, and emits result beats.
module pmt_back #(
    parameter int NUM_CHANNELS = pmt_pkg::NUM_CHANNELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmt_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  pmt_pkg::t_job  i_job,
    output logic           o_pop,
    pmt_out_if.source      o_out
);
    import pmt_pkg::*;

    localparam int NCH = (NUM_CHANNELS > STORE_DEPTH) ? STORE_DEPTH : NUM_CHANNELS;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NCH - 1);

    t_state              r_state, n_state;
    t_job                r_job, n_job;
    logic [CH_W-1:0]     r_idx, n_idx;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [7:0]          r_rem, n_rem;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic [TIME_W-1:0]   r_time [STORE_DEPTH];
    logic [TIME_W-1:0]   n_time [STORE_DEPTH];
    logic                r_blink, n_blink;
    logic [3:0]          r_mcount, n_mcount;
    logic                r_save, n_save;
    logic                r_any, n_any;
    logic                r_ovalid, n_ovalid;
    t_beat               r_obeat, n_obeat;

    logic [TIME_W-1:0]   cur_t;
    logic                cur_fuse;
    logic                single;
    logic                beat_last;
    logic                fire;
    logic [23:0]         prod_mul;
    logic [8:0]          rem_s;
    logic                div_ge;
    logic [TIME_W-1:0]   grant;
    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   tick_t;
    logic [3:0]          mc_inc;
    logic [26:0]         div10;
    t_beat               beat;

    assign cur_t     = r_time[r_idx];
    assign cur_fuse  = r_job.fuse_ok_mask[r_idx];
    assign single    = (r_job.cmd == CMD_ADD_MONEY) || (r_job.cmd == CMD_CLEAR_ONE);
    assign beat_last = single || (r_idx == LAST_CH);
    assign fire      = (r_state == ST_EMIT) && (!r_ovalid || o_out.ready);
    assign o_pop     = (r_state == ST_IDLE) && i_valid;

    // Grant arithmetic pieces
    assign prod_mul = {8'd0, r_job.money} * {16'd0, i_cfg.min_per_unit};
    assign rem_s    = {r_rem, r_prod[PROD_W-1]};
    assign div_ge   = (rem_s >= {1'b0, i_cfg.money_per_unit});
    assign grant    = (r_prod > PROD_W'(TIME_CAP)) ? TIME_CAP : r_prod[TIME_W-1:0];
    assign sum      = {1'b0, cur_t} + {1'b0, grant};
    assign tick_t   = (cur_t > TICK_STEP) ? (cur_t - TICK_STEP) : '0;
    assign mc_inc   = r_mcount + 4'd1;

    // Divide by ten through the reciprocal
    assign div10 = {13'd0, cur_t} * {14'd0, RECIP_10};

    // Build the result beat for the channel at the walk index
    always_comb begin
        beat.out_channel    = r_idx;
        beat.remaining_time = cur_t;
        beat.display_kind   = KIND_ERROR;
        beat.display_value  = '0;
        beat.relay_on       = 1'b0;
        beat.save_request   = r_save;
        beat.last           = beat_last;
        if (r_job.cmd == CMD_DISP_TICK) begin
            if (!cur_fuse) begin
                beat.remaining_time = '0;
                beat.display_kind   = KIND_ERROR;
            end else if (cur_t == '0) begin
                beat.display_kind = r_blink ? KIND_BLANK : KIND_NULL;
            end else begin
                beat.display_kind  = KIND_TIME;
                beat.display_value = div10[16 +: VALUE_W];
                beat.relay_on      = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_job.cmd)
                        CMD_ADD_MONEY:   n_state = ST_MUL;
                        CMD_MINUTE_TICK: n_state = ST_SWEEP;
                        CMD_DISP_TICK:   n_state = ST_SWEEP;
                        default:         n_state = ST_EMIT;
                    endcase
                end
            end
            ST_MUL:   n_state = ST_SCALE;
            ST_SCALE: n_state = (i_cfg.money_per_unit == 8'd0) ? ST_ADD : ST_DIV;
            ST_DIV:   n_state = (r_dcnt == DIV_LAST) ? ST_ADD : ST_DIV;
            ST_ADD:   n_state = ST_EMIT;
            ST_SWEEP: n_state = (r_idx == LAST_CH) ? ST_EMIT : ST_SWEEP;
            ST_EMIT:  n_state = (fire && beat_last) ? ST_IDLE : ST_EMIT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb begin
        n_job    = r_job;
        n_idx    = r_idx;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_time   = r_time;
        n_blink  = r_blink;
        n_mcount = r_mcount;
        n_save   = r_save;
        n_any    = r_any;
        n_ovalid = r_ovalid;
        n_obeat  = r_obeat;

        // Drop the held beat once taken
        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_job  = i_job;
                    n_save = 1'b0;
                    n_any  = 1'b0;
                    n_idx  = '0;
                    case (i_job.cmd)
                        CMD_ADD_MONEY: begin
                            n_idx = i_job.channel;
                        end
                        CMD_DISP_TICK: begin
                            n_blink = !r_blink;
                        end
                        CMD_CLEAR_ONE: begin
                            n_idx                  = i_job.channel;
                            n_time[i_job.channel]  = '0;
                            n_save                 = 1'b1;
                        end
                        CMD_CLEAR_ALL: begin
                            for (int c = 0; c < STORE_DEPTH; c++) begin
                                n_time[c] = '0;
                            end
                            n_save = 1'b1;
                        end
                        default: begin
                            n_save = 1'b0;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_prod = {4'd0, prod_mul};
            end
            ST_SCALE: begin
                // Times ten as eight plus two
                n_prod = {r_prod[PROD_W-4:0], 3'b000} + {r_prod[PROD_W-2:0], 1'b0};
                n_rem  = '0;
                n_dcnt = '0;
                if (i_cfg.money_per_unit == 8'd0) begin
                    n_prod = '0;
                end
            end
            ST_DIV: begin
                // One restoring step; quotient bits shift in at the bottom
                n_rem  = div_ge ? 8'(rem_s - {1'b0, i_cfg.money_per_unit}) : rem_s[7:0];
                n_prod = {r_prod[PROD_W-2:0], div_ge};
                n_dcnt = r_dcnt + 1'b1;
            end
            ST_ADD: begin
                n_time[r_idx] = (sum > {1'b0, TIME_CAP}) ? TIME_CAP : sum[TIME_W-1:0];
                n_save        = 1'b1;
            end
            ST_SWEEP: begin
                if (r_job.cmd == CMD_MINUTE_TICK) begin
                    n_time[r_idx] = tick_t;
                    if ((cur_t != '0) && (cur_t <= TICK_STEP)) begin
                        n_save = 1'b1;
                    end
                    n_any = r_any || (tick_t != '0);
                    if (r_idx == LAST_CH) begin
                        if (mc_inc >= SAVE_PERIOD) begin
                            n_mcount = '0;
                            if (r_any || (tick_t != '0)) begin
                                n_save = 1'b1;
                            end
                        end else begin
                            n_mcount = mc_inc;
                        end
                    end
                end else begin
                    // Blown fuse clears the channel
                    if (!cur_fuse && (cur_t != '0)) begin
                        n_time[r_idx] = '0;
                        n_save        = 1'b1;
                    end
                end
                n_idx = (r_idx == LAST_CH) ? '0 : r_idx + 1'b1;
            end
            ST_EMIT: begin
                if (fire) begin
                    n_ovalid = 1'b1;
                    n_obeat  = beat;
                    n_idx    = r_idx + 1'b1;
                end
            end
            default: begin
                n_ovalid = r_ovalid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_blink  <= 1'b0;
            r_mcount <= '0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < STORE_DEPTH; c++) begin
                r_time[c] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_blink  <= n_blink;
            r_mcount <= n_mcount;
            r_ovalid <= n_ovalid;
            r_time   <= n_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_idx   <= n_idx;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_save  <= n_save;
        r_any   <= n_any;
        r_obeat <= n_obeat;
    end

    // Drive the result channel from the output register
    assign o_out.valid          = r_ovalid;
    assign o_out.out_channel    = r_obeat.out_channel;
    assign o_out.remaining_time = r_obeat.remaining_time;
    assign o_out.display_kind   = r_obeat.display_kind;
    assign o_out.display_value  = r_obeat.display_value;
    assign o_out.relay_on       = r_obeat.relay_on;
    assign o_out.save_request   = r_obeat.save_request;
    assign o_out.last           = r_obeat.last;

endmodule

[tb/prepaid_multichannel_timer_tb.sv]
// Self-checking testbench for the prepaid multichannel timer: command beats in, result beats out.
module prepaid_multichannel_timer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pmt_pkg::*;

    localparam int NCH        = 8;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 100;

    // Per-channel time ledger: predicts every result beat of an accepted command
    class channel_time_model;
        logic [TIME_W-1:0] tenths_left [NCH];
        logic              blink;
        logic [3:0]        ticks_since_save;
        logic [7:0]        minutes_per_unit;
        logic [7:0]        money_per_unit;
        logic              factory;
        t_beat             pending [$];
        int                mismatches;

        function new();
            foreach (tenths_left[c]) tenths_left[c] = '0;
            blink            = 1'b0;
            ticks_since_save = '0;
            minutes_per_unit = 8'd1;
            money_per_unit   = 8'd1;
            factory          = 1'b0;
            mismatches       = 0;
        endfunction

        function void set_register(t_reg idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_MIN_PER_UNIT:   minutes_per_unit = value[7:0];
                REG_MONEY_PER_UNIT: money_per_unit   = value[7:0];
                REG_FACTORY_MODE:   factory          = value[0];
                default: ;
            endcase
        endfunction

        // Plain status beat: display fields stay zero outside a display tick
        function t_beat status_beat(int ch, logic [TIME_W-1:0] tenths);
            t_beat b;
            b                = '0;
            b.out_channel    = CH_W'(ch);
            b.remaining_time = tenths;
            b.display_kind   = KIND_ERROR;
            return b;
        endfunction

        function void take_command(logic [2:0] cmd, logic [CH_W-1:0] ch,
                                   logic [MONEY_W-1:0] money, logic [FUSE_W-1:0] fuse);
            t_beat       fresh [$];
            t_beat       b;
            logic        save;
            bit          any_left;
            int unsigned grant;
            int unsigned sum;
            save     = 1'b0;
            any_left = 1'b0;
            case (cmd)
                CMD_ADD_MONEY: begin
                    if (ch < NCH) begin
                        grant = 0;
                        if (money_per_unit != 0)
                            grant = (32'(money) * 32'(minutes_per_unit) * 32'd10)
                                    / 32'(money_per_unit);
                        sum = 32'(tenths_left[ch]) + grant;
                        if (sum > 32'(TIME_CAP)) sum = 32'(TIME_CAP);
                        tenths_left[ch] = TIME_W'(sum);
                        fresh.push_back(status_beat(int'(ch), tenths_left[ch]));
                        save = 1'b1;
                    end
                end
                CMD_MINUTE_TICK: begin
                    // Drain ten tenths per channel; a channel at or below the step empties
                    for (int c = 0; c < NCH; c++) begin
                        if (tenths_left[c] > TICK_STEP) begin
                            tenths_left[c] = tenths_left[c] - TICK_STEP;
                        end else if (tenths_left[c] != 0) begin
                            tenths_left[c] = '0;
                            save = 1'b1;
                        end
                    end
                    ticks_since_save = ticks_since_save + 4'd1;
                    if (ticks_since_save >= SAVE_PERIOD) begin
                        ticks_since_save = '0;
                        for (int c = 0; c < NCH; c++)
                            if (tenths_left[c] != 0) any_left = 1'b1;
                        if (any_left) save = 1'b1;
                    end
                    for (int c = 0; c < NCH; c++)
                        fresh.push_back(status_beat(c, tenths_left[c]));
                end
                CMD_DISP_TICK: begin
                    if (!factory) begin
                        blink = ~blink;
                        for (int c = 0; c < NCH; c++) begin
                            b = status_beat(c, '0);
                            if (!fuse[c]) begin
                                // Blown fuse: show error and drop the channel's time
                                if (tenths_left[c] != 0) begin
                                    tenths_left[c] = '0;
                                    save = 1'b1;
                                end
                            end else if (tenths_left[c] == 0) begin
                                b.display_kind = blink ? KIND_BLANK : KIND_NULL;
                            end else begin
                                b.remaining_time = tenths_left[c];
                                b.display_kind   = KIND_TIME;
                                b.display_value  = VALUE_W'(tenths_left[c] / 10);
                                b.relay_on       = 1'b1;
                            end
                            fresh.push_back(b);
                        end
                    end
                end
                CMD_CLEAR_ONE: begin
                    if (ch < NCH) begin
                        tenths_left[ch] = '0;
                        fresh.push_back(status_beat(int'(ch), '0));
                        save = 1'b1;
                    end
                end
                CMD_CLEAR_ALL: begin
                    for (int c = 0; c < NCH; c++) begin
                        tenths_left[c] = '0;
                        fresh.push_back(status_beat(c, '0));
                    end
                    save = 1'b1;
                end
                default: ;
            endcase
            // Stamp the item-wide save flag and mark the closing beat
            foreach (fresh[k]) begin
                fresh[k].save_request = save;
                fresh[k].last         = (k == fresh.size() - 1);
                pending.push_back(fresh[k]);
            end
        endfunction

        function string beat_text(t_beat b);
            return $sformatf("ch=%0d time=%0d kind=%0d value=%0d relay=%0b save=%0b last=%0b",
                             b.out_channel, b.remaining_time, b.display_kind,
                             b.display_value, b.relay_on, b.save_request, b.last);
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: beat with nothing pending: %s", $realtime, beat_text(got));
                return;
            end
            want = pending.pop_front();
            if (got.out_channel    !== want.out_channel    ||
                got.remaining_time !== want.remaining_time ||
                got.display_kind   !== want.display_kind   ||
                got.display_value  !== want.display_value  ||
                got.relay_on       !== want.relay_on       ||
                got.save_request   !== want.save_request   ||
                got.last           !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: beat mismatch", $realtime);
                    $display("  expected %s", beat_text(want));
                    $display("  actual   %s", beat_text(got));
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    pmt_in_if  cmd_bus ();
    pmt_out_if beat_bus ();

    channel_time_model model;
    bit                src_steady;
    bit                sink_steady;
    int                cycles;

    prepaid_multichannel_timer #(
        .NUM_CHANNELS (NCH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus),
        .o_out   (beat_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result sink: stall at random, with stretches of steady acceptance
    initial begin
        int hold_left;
        int mode_left;
        hold_left      = 0;
        mode_left      = 0;
        sink_steady    = 1'b0;
        beat_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                sink_steady = ($urandom_range(0, 3) == 0);
                mode_left   = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                beat_bus.ready = 1'b0;
            end else begin
                beat_bus.ready = 1'b1;
                if (!sink_steady && $urandom_range(0, 3) == 0) hold_left = pick_gap();
            end
        end
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin : collect_beats
        t_beat got;
        if (i_rst_n && beat_bus.valid && beat_bus.ready) begin
            got.out_channel    = beat_bus.out_channel;
            got.remaining_time = beat_bus.remaining_time;
            got.display_kind   = t_kind'(beat_bus.display_kind);
            got.display_value  = beat_bus.display_value;
            got.relay_on       = beat_bus.relay_on;
            got.save_request   = beat_bus.save_request;
            got.last           = beat_bus.last;
            model.check_beat(got);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_CAP) begin
            $display("prepaid_multichannel_timer verification failed");
            $finish;
        end
    end

    // Offer one command beat and hold it until taken
    task automatic push_command(logic [2:0] cmd, logic [CH_W-1:0] ch,
                                logic [MONEY_W-1:0] money, logic [FUSE_W-1:0] fuse);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            cmd_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid        = 1'b1;
        cmd_bus.cmd          = cmd;
        cmd_bus.channel      = ch;
        cmd_bus.money        = money;
        cmd_bus.fuse_ok_mask = fuse;
        do @(posedge i_clk); while (!cmd_bus.ready);
        model.take_command(cmd, ch, money, fuse);
        @(negedge i_clk);
    endtask

    // Wait for all pending beats, then let a dropped command finish inside the block
    task automatic settle();
        cmd_bus.valid = 1'b0;
        while (model.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_register(t_reg idx, logic [DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx) << 2;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        model.set_register(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(logic [7:0] per_unit, logic [7:0] divisor, logic factory);
        settle();
        write_register(REG_MIN_PER_UNIT, DATA_W'(per_unit));
        write_register(REG_MONEY_PER_UNIT, DATA_W'(divisor));
        write_register(REG_FACTORY_MODE, DATA_W'(factory));
    endtask

    // Random commands: mostly coins and ticks, some clears and unused codes
    task automatic run_random(int count);
        int                 r;
        int                 burst_left;
        logic [2:0]         cmd;
        logic [MONEY_W-1:0] money;
        logic [FUSE_W-1:0]  fuse;
        burst_left = 0;
        repeat (count) begin
            if (burst_left == 0) begin
                src_steady = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(5, 25);
            end else begin
                burst_left--;
            end
            r = $urandom_range(0, 99);
            if (r < 35)      cmd = CMD_ADD_MONEY;
            else if (r < 60) cmd = CMD_MINUTE_TICK;
            else if (r < 80) cmd = CMD_DISP_TICK;
            else if (r < 88) cmd = CMD_CLEAR_ONE;
            else if (r < 92) cmd = CMD_CLEAR_ALL;
            else             cmd = 3'($urandom_range(5, 7));
            r = $urandom_range(0, 99);
            if (r < 60)      money = MONEY_W'($urandom_range(0, 30));
            else if (r < 85) money = MONEY_W'($urandom_range(0, 1000));
            else             money = MONEY_W'($urandom_range(0, 65535));
            fuse = ($urandom_range(0, 9) < 7) ? 8'hFF : FUSE_W'($urandom_range(0, 255));
            push_command(cmd, CH_W'($urandom_range(0, NCH - 1)), money, fuse);
        end
        src_steady = 1'b0;
    endtask

    initial begin
        model                = new();
        cycles               = 0;
        src_steady           = 1'b0;
        i_rst_n              = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.cmd          = '0;
        cmd_bus.channel      = '0;
        cmd_bus.money        = '0;
        cmd_bus.fuse_ok_mask = '0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: grants, saturation, empty coin, tick clearing, blink, fuses, clears
        push_command(CMD_ADD_MONEY,   3'd0, 16'd5,     8'h00);
        push_command(CMD_ADD_MONEY,   3'd1, 16'd1,     8'h00);
        push_command(CMD_ADD_MONEY,   3'd2, 16'hFFFF,  8'hFF);
        push_command(CMD_ADD_MONEY,   3'd7, 16'd0,     8'h00);
        push_command(CMD_ADD_MONEY,   3'd2, 16'd1,     8'h00);
        push_command(CMD_MINUTE_TICK, 3'd0, 16'd0,     8'h00);
        push_command(CMD_DISP_TICK,   3'd0, 16'd0,     8'hFF);
        push_command(CMD_DISP_TICK,   3'd0, 16'd0,     8'hFF);
        push_command(CMD_DISP_TICK,   3'd0, 16'd0,     8'hFB);
        push_command(CMD_DISP_TICK,   3'd0, 16'd0,     8'h00);
        push_command(CMD_ADD_MONEY,   3'd3, 16'd300,   8'h00);
        push_command(CMD_ADD_MONEY,   3'd5, 16'd2,     8'h00);
        push_command(CMD_CLEAR_ONE,   3'd3, 16'd0,     8'h00);
        push_command(3'd5,            3'd7, 16'hFFFF,  8'hFF);
        push_command(3'd6,            3'd2, 16'h5A5A,  8'h3C);
        push_command(3'd7,            3'd5, 16'hA5A5,  8'hC3);
        push_command(CMD_ADD_MONEY,   3'd6, 16'd200,   8'h00);
        repeat (9) push_command(CMD_MINUTE_TICK, 3'd0, 16'd0, 8'h00);
        push_command(CMD_CLEAR_ALL,   3'd0, 16'd0,     8'h00);
        run_random(60);

        // Largest grant rate, saturating quickly
        configure(8'd255, 8'd1, 1'b0);
        run_random(40);

        // Largest divisor with display ticks suppressed
        configure(8'd7, 8'd255, 1'b1);
        run_random(40);

        // Zero divisor and zero rate: coins add nothing
        configure(8'd0, 8'd0, 1'b0);
        run_random(25);

        // Fractional grant rate
        configure(8'd3, 8'd2, 1'b0);
        run_random(45);

        cmd_bus.valid = 1'b0;
        while (model.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (model.mismatches == 0 && model.pending.size() == 0)
            $display("prepaid_multichannel_timer verification clean");
        else
            $display("prepaid_multichannel_timer verification failed");
        $finish;
    end

endmodule

[prepaid_multichannel_timer.f]
design/pmt_pkg.sv
design/pmt_ifs.sv
design/pmt_front.sv
design/pmt_queue.sv
design/pmt_back.sv
design/prepaid_multichannel_timer.sv
tb/prepaid_multichannel_timer_tb.sv
